[sv/assert_macros.svh]
// Assertion macros for the grid search block.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked at every clock edge
`define GBSP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("gbsp assertion failed");

// Same-cycle implication
`define GBSP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gbsp assertion failed");

`endif

[sv/gbsp_pkg.sv]
// Shared types and constants of the grid search block.
// No dependencies; used by gbsp_ctrl, gbsp_datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package gbsp_pkg;

  localparam int unsigned MAX_SIDE   = 32;
  localparam int unsigned COORD_W    = $clog2(MAX_SIDE);
  localparam int unsigned IDX_W      = 2 * COORD_W;
  localparam int unsigned CELL_COUNT = MAX_SIDE * MAX_SIDE;
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned SIDE_W     = COORD_W + 1;
  localparam int unsigned LEN_W      = 11;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_RUN  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CODE_EMPTY = 2'd0,
    CODE_OBST  = 2'd1,
    CODE_GOAL  = 2'd2,
    CODE_ROUTE = 2'd3
  } cell_code_e;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic [1:0]         cell_in;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [LEN_W-1:0] path_length;
    logic [1:0]       cell_out;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_READ,
    OP_RUN_INIT,
    OP_SWEEP,
    OP_RD_START,
    OP_START_PUSH,
    OP_DEQ,
    OP_CELL_RD,
    OP_NB_ISSUE,
    OP_NB_STEP,
    OP_TR_INIT,
    OP_TR_RD,
    OP_TR_UPD,
    OP_OUT_RUN,
    OP_OUT_READ
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic start_obst;
    logic q_empty;
    logic is_goal;
    logic nb_last;
    logic tr_at_start;
    logic out_free;
  } dp_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_OUT,
    ST_SWEEP,
    ST_START_RD,
    ST_START_CHK,
    ST_DEQ,
    ST_CELL_RD,
    ST_CELL_CHK,
    ST_NB,
    ST_TR_RD,
    ST_TR_UPD,
    ST_RES
  } ctrl_state_e;

endpackage

`default_nettype wire

[sv/gbsp_datapath.sv]
// Datapath of the grid search: cell, seen, parent and queue memories,
// counters, config registers and the output register. Uses gbsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gbsp_datapath
  import gbsp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire in_item_t    in_item_i,
  input  wire dp_cmd_t     cmd_i,
  output dp_stat_t         stat_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [5:0]  cfg_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_item_o
);

  // Memories
  logic [1:0]       grid_mem   [CELL_COUNT];
  logic             seen_mem   [CELL_COUNT];
  logic [1:0]       parent_mem [CELL_COUNT];
  logic [IDX_W-1:0] queue_mem  [CELL_COUNT];

  logic [SIDE_W-1:0] width_q, height_q;
  logic [CNT_W-1:0]  sweep_q, head_q, tail_q;
  logic [IDX_W-1:0]  cur_q, pend_n_q, tr_idx_q;
  logic [1:0]        pend_dir_q;
  logic              pend_inb_q;
  logic [2:0]        nb_dir_q;
  logic [LEN_W-1:0]  len_q;
  logic              found_q;
  logic [1:0]        grid_rd_q, parent_rd_q;
  logic              seen_rd_q;
  logic [IDX_W-1:0]  queue_rd_q;
  out_item_t         out_q;
  logic              out_valid_q;

  dp_op_e op;
  assign op = cmd_i.op;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIDE_W'(MAX_SIDE);
      height_q <= SIDE_W'(MAX_SIDE);
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_WIDTH) width_q <= cfg_data_i[SIDE_W-1:0];
      else height_q <= cfg_data_i[SIDE_W-1:0];
    end
  end

  // Clamp sizes to 1..MAX_SIDE
  logic [SIDE_W-1:0] w_eff, h_eff;
  always_comb begin
    w_eff = width_q;
    if (width_q == '0) w_eff = SIDE_W'(1);
    else if (width_q > SIDE_W'(MAX_SIDE)) w_eff = SIDE_W'(MAX_SIDE);
    h_eff = height_q;
    if (height_q == '0) h_eff = SIDE_W'(1);
    else if (height_q > SIDE_W'(MAX_SIDE)) h_eff = SIDE_W'(MAX_SIDE);
  end

  // Neighbor address for the direction being issued
  logic [1:0]         nb_dir;
  logic               nb_issue;
  logic [COORD_W-1:0] cx, cy;
  logic [SIDE_W-1:0]  nx, ny;
  logic               nb_inb;
  logic [IDX_W-1:0]   nb_idx;
  always_comb begin
    nb_dir   = (op == OP_NB_ISSUE) ? 2'd0 : nb_dir_q[1:0];
    nb_issue = (op == OP_NB_ISSUE) || ((op == OP_NB_STEP) && !nb_dir_q[2]);
    cx = cur_q[COORD_W-1:0];
    cy = cur_q[IDX_W-1:COORD_W];
    nx = {1'b0, cx};
    ny = {1'b0, cy};
    nb_inb = 1'b1;
    case (nb_dir)
      2'd0: nx = {1'b0, cx} + SIDE_W'(1);
      2'd1: ny = {1'b0, cy} + SIDE_W'(1);
      2'd2: begin
        nx = {1'b0, cx} - SIDE_W'(1);
        if (cx == '0) nb_inb = 1'b0;
      end
      default: begin
        ny = {1'b0, cy} - SIDE_W'(1);
        if (cy == '0) nb_inb = 1'b0;
      end
    endcase
    if (nx >= w_eff || ny >= h_eff) nb_inb = 1'b0;
    nb_idx = {ny[COORD_W-1:0], nx[COORD_W-1:0]};
  end

  // Enqueue decision for the pending neighbor
  logic push;
  assign push = (op == OP_NB_STEP) && pend_inb_q && !seen_rd_q &&
                (grid_rd_q != CODE_OBST) && !tail_q[CNT_W-1];

  // Parent cell of the trace position
  logic [COORD_W-1:0] tx, ty;
  always_comb begin
    tx = tr_idx_q[COORD_W-1:0];
    ty = tr_idx_q[IDX_W-1:COORD_W];
    case (parent_rd_q)
      2'd0:    tx = tx - COORD_W'(1);
      2'd1:    ty = ty - COORD_W'(1);
      2'd2:    tx = tx + COORD_W'(1);
      default: ty = ty + COORD_W'(1);
    endcase
  end

  // Grid memory port selection
  logic             g_we, g_re;
  logic [IDX_W-1:0] g_wa, g_ra;
  logic [1:0]       g_wd;
  logic [IDX_W-1:0] sweep_prev;
  assign sweep_prev = sweep_q[IDX_W-1:0] - IDX_W'(1);
  always_comb begin
    g_we = 1'b0;
    g_wa = '0;
    g_wd = CODE_EMPTY;
    g_re = 1'b0;
    g_ra = '0;
    case (op)
      OP_LOAD: begin
        g_we = 1'b1;
        g_wa = {in_item_i.y_coord, in_item_i.x_coord};
        g_wd = (in_item_i.cell_in == CODE_ROUTE) ? CODE_OBST : in_item_i.cell_in;
      end
      OP_READ: begin
        g_re = 1'b1;
        g_ra = {in_item_i.y_coord, in_item_i.x_coord};
      end
      OP_SWEEP: begin
        g_re = !sweep_q[CNT_W-1];
        g_ra = sweep_q[IDX_W-1:0];
        g_we = (sweep_q != '0) && (grid_rd_q == CODE_ROUTE);
        g_wa = sweep_prev;
        g_wd = CODE_EMPTY;
      end
      OP_RD_START: begin
        g_re = 1'b1;
        g_ra = '0;
      end
      OP_CELL_RD: begin
        g_re = 1'b1;
        g_ra = queue_rd_q;
      end
      OP_NB_ISSUE, OP_NB_STEP: begin
        g_re = nb_issue;
        g_ra = nb_idx;
      end
      OP_TR_RD: begin
        g_re = 1'b1;
        g_ra = tr_idx_q;
      end
      OP_TR_UPD: begin
        g_we = (grid_rd_q == CODE_EMPTY);
        g_wa = tr_idx_q;
        g_wd = CODE_ROUTE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (g_we) grid_mem[g_wa] <= g_wd;
    if (g_re) grid_rd_q <= grid_mem[g_ra];
  end

  // Seen marks: cleared by the sweep, set on enqueue
  logic             s_we, s_wd;
  logic [IDX_W-1:0] s_wa;
  always_comb begin
    s_we = 1'b0;
    s_wa = pend_n_q;
    s_wd = 1'b1;
    if (op == OP_SWEEP) begin
      s_we = !sweep_q[CNT_W-1];
      s_wa = sweep_q[IDX_W-1:0];
      s_wd = 1'b0;
    end else if (op == OP_START_PUSH) begin
      s_we = 1'b1;
      s_wa = '0;
    end else if (push) begin
      s_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_we) seen_mem[s_wa] <= s_wd;
    if (nb_issue) seen_rd_q <= seen_mem[nb_idx];
  end

  // Parent directions
  always_ff @(posedge clk_i) begin
    if (push) parent_mem[pend_n_q] <= pend_dir_q;
    if (op == OP_TR_RD) parent_rd_q <= parent_mem[tr_idx_q];
  end

  // Search queue
  always_ff @(posedge clk_i) begin
    if (op == OP_START_PUSH) queue_mem[0] <= '0;
    else if (push) queue_mem[tail_q[IDX_W-1:0]] <= pend_n_q;
    if (op == OP_DEQ) queue_rd_q <= queue_mem[head_q[IDX_W-1:0]];
  end

  // Counters and search control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q  <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      nb_dir_q <= '0;
      len_q    <= '0;
      found_q  <= 1'b0;
    end else begin
      case (op)
        OP_RUN_INIT: begin
          sweep_q <= '0;
          head_q  <= '0;
          tail_q  <= '0;
          len_q   <= '0;
          found_q <= 1'b0;
        end
        OP_SWEEP: if (!sweep_q[CNT_W-1]) sweep_q <= sweep_q + CNT_W'(1);
        OP_START_PUSH: tail_q <= CNT_W'(1);
        OP_DEQ: head_q <= head_q + CNT_W'(1);
        OP_TR_INIT: len_q <= '0;
        OP_TR_UPD: begin
          len_q <= len_q + LEN_W'(1);
          if (tr_idx_q == '0) found_q <= 1'b1;
        end
        default: ;
      endcase
      if (push) tail_q <= tail_q + CNT_W'(1);
      if (nb_issue) nb_dir_q <= {1'b0, nb_dir} + 3'd1;
    end
  end

  // Payload registers of the search
  always_ff @(posedge clk_i) begin
    if (op == OP_CELL_RD) cur_q <= queue_rd_q;
    if (nb_issue) begin
      pend_n_q   <= nb_idx;
      pend_dir_q <= nb_dir;
      pend_inb_q <= nb_inb;
    end
    if (op == OP_TR_INIT) tr_idx_q <= cur_q;
    else if (op == OP_TR_UPD) tr_idx_q <= {ty, tx};
  end

  // Output register
  logic out_load;
  assign out_load = (op == OP_OUT_RUN) || (op == OP_OUT_READ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (out_load) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (op == OP_OUT_RUN) begin
      out_q.found       <= found_q;
      out_q.path_length <= len_q;
      out_q.cell_out    <= CODE_EMPTY;
    end else if (op == OP_OUT_READ) begin
      out_q.found       <= 1'b0;
      out_q.path_length <= '0;
      out_q.cell_out    <= grid_rd_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Status back to the controller
  always_comb begin
    stat_o.sweep_done  = sweep_q[CNT_W-1];
    stat_o.start_obst  = (grid_rd_q == CODE_OBST);
    stat_o.q_empty     = (head_q == tail_q);
    stat_o.is_goal     = (grid_rd_q == CODE_GOAL);
    stat_o.nb_last     = nb_dir_q[2];
    stat_o.tr_at_start = (tr_idx_q == '0);
    stat_o.out_free    = !out_valid_q || out_ready_i;
  end

  // Checks
  `GBSP_ASSERT(a_head_le_tail, head_q <= tail_q)
  `GBSP_ASSERT(a_tail_bound, tail_q <= CNT_W'(CELL_COUNT))
  `GBSP_ASSERT_IMPL(a_push_inb, push, pend_inb_q)
  `GBSP_ASSERT_IMPL(a_no_overwrite, out_valid_q && !out_ready_i, !out_load)

endmodule

`default_nettype wire

[sv/gbsp_ctrl.sv]
// Controller state machine of the grid search: sequences load, read and
// the sweep / breadth-first search / route trace of a run. Uses gbsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbsp_ctrl
  import gbsp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] command_i,
  input  wire dp_stat_t   stat_i,
  output dp_cmd_t         cmd_o
);

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // Next state and datapath commands
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (command_i)
            CMD_LOAD: cmd_o.op = OP_LOAD;
            CMD_READ: begin
              cmd_o.op = OP_READ;
              state_d  = ST_RD_OUT;
            end
            CMD_RUN: begin
              cmd_o.op = OP_RUN_INIT;
              state_d  = ST_SWEEP;
            end
            default: ;
          endcase
        end
      end
      ST_RD_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_OUT_READ;
          state_d  = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        cmd_o.op = OP_SWEEP;
        if (stat_i.sweep_done) state_d = ST_START_RD;
      end
      ST_START_RD: begin
        cmd_o.op = OP_RD_START;
        state_d  = ST_START_CHK;
      end
      ST_START_CHK: begin
        if (stat_i.start_obst) state_d = ST_RES;
        else begin
          cmd_o.op = OP_START_PUSH;
          state_d  = ST_DEQ;
        end
      end
      ST_DEQ: begin
        if (stat_i.q_empty) state_d = ST_RES;
        else begin
          cmd_o.op = OP_DEQ;
          state_d  = ST_CELL_RD;
        end
      end
      ST_CELL_RD: begin
        cmd_o.op = OP_CELL_RD;
        state_d  = ST_CELL_CHK;
      end
      ST_CELL_CHK: begin
        if (stat_i.is_goal) begin
          cmd_o.op = OP_TR_INIT;
          state_d  = ST_TR_RD;
        end else begin
          cmd_o.op = OP_NB_ISSUE;
          state_d  = ST_NB;
        end
      end
      ST_NB: begin
        cmd_o.op = OP_NB_STEP;
        if (stat_i.nb_last) state_d = ST_DEQ;
      end
      ST_TR_RD: begin
        cmd_o.op = OP_TR_RD;
        state_d  = ST_TR_UPD;
      end
      ST_TR_UPD: begin
        cmd_o.op = OP_TR_UPD;
        state_d  = stat_i.tr_at_start ? ST_RES : ST_TR_RD;
      end
      ST_RES: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_OUT_RUN;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[sv/grid_bfs_shortest_path_core.sv]
// Top level of the grid shortest-path block (breadth-first maze search).
// Instantiates gbsp_ctrl and gbsp_datapath; types from gbsp_pkg.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+--------------------------------
//   in       | in_valid_i/in_ready_o | in_item_i (command, x, y, cell)
//   out      | out_valid_o/out_ready_i | out_item_o (found, length, cell)
//   cfg      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Load writes the cell; read fetches the cell, then loads the output
// register. A run first sweeps to clear seen marks and old route marks, then
// dequeues cells (queue read, cell read, four neighbor lookups on one memory port),
// then traces the path back from the goal cell by cell, marking the route.
// Reset is asynchronous, active low; cell memory contents are not reset.
// A new read or run result waits until the previous one is taken on out_ready_i.
`timescale 1ns / 1ps
`default_nettype none

module grid_bfs_shortest_path_core
  import gbsp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire in_item_t   in_item_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output out_item_t       out_item_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [5:0] cfg_data_i
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  logic     cfg_we;

  // Config writes are always taken; indexes past the list are dropped
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && (cfg_index_i[1] == 1'b0);

  gbsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (in_item_i.command),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  gbsp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i[0]),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
